FILE: rtl/core/rtp_pkg.sv
// shared types and constants of the ringtone text parser
`default_nettype none
package rtp_pkg;

  typedef enum logic [13:0] {
    PH_NAME   = 14'b00000000000001,
    PH_DSTART = 14'b00000000000010,
    PH_DEQ    = 14'b00000000000100,
    PH_DVAL   = 14'b00000000001000,
    PH_DTAIL  = 14'b00000000010000,
    PH_NTOP   = 14'b00000000100000,
    PH_NSKIP  = 14'b00000001000000,
    PH_NDUR   = 14'b00000010000000,
    PH_SHARP  = 14'b00000100000000,
    PH_FLAT   = 14'b00001000000000,
    PH_DOT1   = 14'b00010000000000,
    PH_OCT    = 14'b00100000000000,
    PH_DOT2   = 14'b01000000000000,
    PH_DELIM  = 14'b10000000000000
  } phase_t;

  typedef enum logic [5:0] {
    SQ_IDLE  = 6'b000001,
    SQ_PARSE = 6'b000010,
    SQ_DIV   = 6'b000100,
    SQ_OUT1  = 6'b001000,
    SQ_OUT2  = 6'b010000,
    SQ_DDIV  = 6'b100000
  } seq_t;

  localparam logic [1:0] ST_NOTE = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_FMT  = 2'd2;
  localparam logic [1:0] ST_ZERO = 2'd3;

  localparam logic [7:0] VOLUME_RESET = 8'd64;
  localparam logic [19:0] END_MS = 20'd500;
  localparam logic [6:0] DUR_RESET = 7'd4;
  localparam logic [3:0] OCT_RESET = 4'd6;
  localparam logic [15:0] MS_SCALE = 16'd60000;
  localparam int DIV_BITS = 23;

  function automatic logic [12:0] top_freq(input logic [3:0] idx);
    logic [12:0] f;
    begin
      case (idx)
        4'd0: f = 13'd4186;
        4'd1: f = 13'd4434;
        4'd2: f = 13'd4698;
        4'd3: f = 13'd4978;
        4'd4: f = 13'd5274;
        4'd5: f = 13'd5587;
        4'd6: f = 13'd5919;
        4'd7: f = 13'd6271;
        4'd8: f = 13'd6644;
        4'd9: f = 13'd7040;
        4'd10: f = 13'd7458;
        4'd11: f = 13'd7902;
        default: f = 13'd0;
      endcase
      return f;
    end
  endfunction

  function automatic logic signed [5:0] letter_semi(input logic [7:0] c);
    logic signed [5:0] s;
    begin
      case (c)
        "C", "c": s = 6'sd0;
        "D", "d": s = 6'sd2;
        "E", "e": s = 6'sd4;
        "F", "f": s = 6'sd5;
        "G", "g": s = 6'sd7;
        "A", "a": s = 6'sd9;
        "H", "h", "B", "b": s = 6'sd11;
        default: s = -6'sd1;
      endcase
      return s;
    end
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/ringtone_text_to_tone_parser.sv
// ringtone text parser: one text byte in, up to two tone results out
// a plain byte is parsed in the parse state, after which the block returns to idle and is ready again
// a note closing byte: the parse states, then the divider for dur*60000/(tempo*8),
//   then the note beat, then the end pause beat if the byte ends the song, else a re-parse of a non-comma byte
// a d= value or note duration digits use the same divider for 32/value
// synchronous active-low reset returns parser state to name phase, volume to 64
`default_nettype none
module ringtone_text_to_tone_parser
  import rtp_pkg::*;
#(
  parameter int ACC_BITS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_tone_volume,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_char_code,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [12:0]      out_tone_freq,
  output logic [7:0]       out_tone_amplitude,
  output logic [19:0]      out_tone_ms,
  output logic [1:0]       out_status,
  output logic             out_is_final
);

  localparam int DW = (ACC_BITS + 3 > DIV_BITS) ? ACC_BITS + 3 : DIV_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam logic [ACC_BITS-1:0] ACC_MAX = {ACC_BITS{1'b1}};

  logic [7:0] vol_r;
  seq_t sq_r, sq_nxt;
  phase_t ph_r, ph_nxt;
  logic [7:0] c_r, c_nxt;
  logic [6:0] ddur_r, ddur_nxt, ndur_r, ndur_nxt;
  logic [3:0] doct_r, doct_nxt, noct_r, noct_nxt;
  logic [ACC_BITS-1:0] tempo_r, tempo_nxt, acc_r, acc_nxt;
  logic [7:0] let_r, let_nxt;
  logic signed [5:0] semi_r, semi_nxt;
  // shared divider
  logic [DW-1:0] dq_r, dq_nxt, dd_r, dd_nxt;
  logic [DW:0] drem_r, drem_nxt;
  logic [CW-1:0] dcnt_r, dcnt_nxt;
  logic dfrom_ndur_r, dfrom_ndur_nxt;
  // result buffer: slot 0 then optional end pause
  logic [12:0] rf_r, rf_nxt;
  logic [19:0] rms_r, rms_nxt;
  logic [1:0] rst_r, rst_nxt;
  logic ramp_r, ramp_nxt, rtwo_r, rtwo_nxt;
  logic again_r, again_nxt;

  logic [DW:0] trial;
  logic [ACC_BITS+3:0] acc10;
  logic [ACC_BITS-1:0] acc_dig;
  logic [3:0] cdig;
  logic isdig;
  logic [4:0] kq;
  logic [3:0] kr;
  logic [3:0] sh;
  logic [ACC_BITS+2:0] tdiv;

  assign cdig = c_r[3:0];
  assign isdig = (c_r >= "0") && (c_r <= "9");
  assign acc10 = {4'd0, acc_r} * (ACC_BITS+4)'(10) + (ACC_BITS+4)'(c_r - "0");
  assign acc_dig = (acc10 > (ACC_BITS+4)'(ACC_MAX)) ? ACC_MAX : acc10[ACC_BITS-1:0];
  assign trial = {drem_r[DW-1:0], dq_r[DW-1]} - {1'b0, dd_r};
  assign tdiv = {tempo_r, 3'b000};

  // octave and table index of the note, semitone -2..12 borrows from or carries into octave
  always_comb begin
    if (semi_r < 0) begin
      kq = {1'b0, noct_r};
      kr = 4'(semi_r + 6'sd12);
    end else if (semi_r > 6'sd11) begin
      kq = {1'b0, noct_r} + 5'd2;
      kr = 4'(semi_r - 6'sd12);
    end else begin
      kq = {1'b0, noct_r} + 5'd1;
      kr = semi_r[3:0];
    end
    sh = (kq >= 5'd9) ? 4'd0 : 4'(5'd9 - kq);
  end

  assign in_ready  = (sq_r == SQ_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = (sq_r == SQ_OUT1) || (sq_r == SQ_OUT2);
  assign out_tone_freq = (sq_r == SQ_OUT1) ? rf_r : 13'd0;
  assign out_tone_amplitude = ((sq_r == SQ_OUT1) && ramp_r) ? vol_r : 8'd0;
  assign out_tone_ms = (sq_r == SQ_OUT1) ? rms_r : END_MS;
  assign out_status = (sq_r == SQ_OUT1) ? rst_r : ST_END;
  assign out_is_final = (sq_r == SQ_OUT2) || !rtwo_r;

  always_comb begin
    sq_nxt = sq_r; ph_nxt = ph_r; c_nxt = c_r;
    ddur_nxt = ddur_r; ndur_nxt = ndur_r; doct_nxt = doct_r; noct_nxt = noct_r;
    tempo_nxt = tempo_r; acc_nxt = acc_r; let_nxt = let_r; semi_nxt = semi_r;
    dq_nxt = dq_r; dd_nxt = dd_r; drem_nxt = drem_r; dcnt_nxt = dcnt_r;
    dfrom_ndur_nxt = dfrom_ndur_r;
    rf_nxt = rf_r; rms_nxt = rms_r; rst_nxt = rst_r; ramp_nxt = ramp_r;
    rtwo_nxt = rtwo_r; again_nxt = 1'b0;
    case (sq_r)
      SQ_IDLE: begin
        if (in_valid) begin
          c_nxt = in_char_code;
          sq_nxt = SQ_PARSE;
        end
      end
      SQ_PARSE: begin
        sq_nxt = SQ_IDLE;
        case (ph_r)
          PH_NAME: begin
            if (c_r == 8'd0) begin
              rst_nxt = ST_FMT; sq_nxt = SQ_OUT1;
            end else if (c_r == ":") ph_nxt = PH_DSTART;
          end
          PH_DSTART: begin
            if (c_r == " ") begin
            end else if (c_r == 8'd0) begin
              rst_nxt = ST_FMT; sq_nxt = SQ_OUT1;
            end else if (c_r == ":") begin
              ph_nxt = PH_NTOP; semi_nxt = -6'sd1; noct_nxt = doct_r;
              ndur_nxt = ddur_r; acc_nxt = '0;
            end else begin
              let_nxt = c_r; ph_nxt = PH_DEQ;
            end
          end
          PH_DEQ: begin
            if (c_r == "=") begin
              acc_nxt = '0; ph_nxt = PH_DVAL;
            end else begin
              rst_nxt = ST_FMT; sq_nxt = SQ_OUT1;
            end
          end
          PH_DVAL: begin
            if (isdig) acc_nxt = acc_dig;
            else begin
              acc_nxt = '0;
              ph_nxt = PH_DTAIL;
              sq_nxt = SQ_PARSE;
              if (let_r == "d") begin
                if (acc_r == '0) begin
                  rst_nxt = ST_ZERO; sq_nxt = SQ_OUT1;
                end else begin
                  // 32 / value on the shared divider
                  dq_nxt = DW'(32) << (DW - 6); dd_nxt = DW'(acc_r);
                  drem_nxt = '0; dcnt_nxt = CW'(6); dfrom_ndur_nxt = 1'b0;
                  sq_nxt = SQ_DDIV;
                end
              end else if (let_r == "o") begin
                doct_nxt = (acc_r > ACC_BITS'(15)) ? 4'd15 : acc_r[3:0];
              end else if (let_r == "b") tempo_nxt = acc_r;
            end
          end
          PH_DTAIL: begin
            if (c_r != " ") begin
              ph_nxt = PH_DSTART;
              if (c_r != ",") sq_nxt = SQ_PARSE;
            end
          end
          PH_NTOP, PH_NSKIP: begin
            if (c_r == " ") ph_nxt = PH_NSKIP;
            else if (c_r == 8'd0) begin
              rst_nxt = (ph_r == PH_NTOP) ? ST_END : ST_FMT;
              rf_nxt = '0; rms_nxt = END_MS; ramp_nxt = 1'b0;
              sq_nxt = (ph_r == PH_NTOP) ? SQ_OUT2 : SQ_OUT1;
            end else if (isdig) begin
              acc_nxt = ACC_BITS'(cdig - 4'd0) - ACC_BITS'("0" & 8'h0f);
              ph_nxt = PH_NDUR;
            end else begin
              semi_nxt = letter_semi(c_r); ph_nxt = PH_SHARP;
            end
          end
          PH_NDUR: begin
            if (isdig) acc_nxt = acc_dig;
            else if (acc_r == '0) begin
              rst_nxt = ST_ZERO; sq_nxt = SQ_OUT1;
            end else begin
              dq_nxt = DW'(32) << (DW - 6); dd_nxt = DW'(acc_r);
              drem_nxt = '0; dcnt_nxt = CW'(6); dfrom_ndur_nxt = 1'b1;
              acc_nxt = '0; sq_nxt = SQ_DDIV;
            end
          end
          PH_SHARP: begin
            ph_nxt = PH_FLAT;
            if (c_r == "#") semi_nxt = semi_r + 6'sd1; else sq_nxt = SQ_PARSE;
          end
          PH_FLAT: begin
            ph_nxt = PH_DOT1;
            if (c_r == "b") semi_nxt = semi_r - 6'sd1; else sq_nxt = SQ_PARSE;
          end
          PH_DOT1: begin
            ph_nxt = PH_OCT;
            if (c_r == ".") ndur_nxt = ndur_r + (ndur_r >> 1); else sq_nxt = SQ_PARSE;
          end
          PH_OCT: begin
            ph_nxt = PH_DOT2;
            if (isdig) noct_nxt = cdig; else sq_nxt = SQ_PARSE;
          end
          PH_DOT2: begin
            ph_nxt = PH_DELIM;
            if (c_r == ".") ndur_nxt = ndur_r + (ndur_r >> 1); else sq_nxt = SQ_PARSE;
          end
          PH_DELIM: begin
            if (c_r != " ") begin
              if (tempo_r == '0) begin
                rst_nxt = ST_ZERO; sq_nxt = SQ_OUT1;
              end else begin
                dq_nxt = DW'(ndur_r) * DW'(MS_SCALE); dd_nxt = DW'(tdiv);
                drem_nxt = '0; dcnt_nxt = CW'(DW); sq_nxt = SQ_DIV;
                again_nxt = (c_r != ",");
              end
            end
          end
          default: begin
            // unused phase codes drop the song silently
            sq_nxt = SQ_IDLE; ph_nxt = PH_NAME;
            ddur_nxt = DUR_RESET; ndur_nxt = DUR_RESET;
            doct_nxt = OCT_RESET; noct_nxt = OCT_RESET;
            tempo_nxt = ACC_BITS'(63); acc_nxt = '0; let_nxt = '0; semi_nxt = -6'sd1;
          end
        endcase
        if (sq_nxt == SQ_OUT1) begin
          rtwo_nxt = 1'b0; rf_nxt = '0; rms_nxt = '0; ramp_nxt = 1'b0;
        end
        if (sq_nxt == SQ_OUT2) rtwo_nxt = 1'b0;
      end
      SQ_DDIV, SQ_DIV: begin
        // restoring divide, one quotient bit a cycle
        if (!trial[DW]) begin
          drem_nxt = trial;
          dq_nxt = {dq_r[DW-2:0], 1'b1};
        end else begin
          drem_nxt = {drem_r[DW-1:0], dq_r[DW-1]};
          dq_nxt = {dq_r[DW-2:0], 1'b0};
        end
        dcnt_nxt = dcnt_r - CW'(1);
        if (dcnt_r == CW'(1)) begin
          if (sq_r == SQ_DDIV) begin
            if (dfrom_ndur_r) begin
              ndur_nxt = 7'(dq_nxt);
              if (c_r == 8'd0) begin
                rst_nxt = ST_FMT; rtwo_nxt = 1'b0; rf_nxt = '0; rms_nxt = '0;
                ramp_nxt = 1'b0; sq_nxt = SQ_OUT1;
              end else begin
                semi_nxt = letter_semi(c_r); ph_nxt = PH_SHARP; sq_nxt = SQ_IDLE;
              end
            end else begin
              ddur_nxt = 7'(dq_nxt); sq_nxt = SQ_PARSE;
            end
          end else begin
            rms_nxt = 20'(dq_nxt);
            rf_nxt = (semi_r == -6'sd1) ? 13'd0 : (top_freq(kr) >> sh);
            // a closing end of string follows the note with the end pause
            rst_nxt = ST_NOTE; ramp_nxt = 1'b1; rtwo_nxt = again_r && (c_r == 8'd0);
            ph_nxt = PH_NTOP; semi_nxt = -6'sd1; noct_nxt = doct_r;
            ndur_nxt = ddur_r; acc_nxt = '0;
            again_nxt = again_r;
            sq_nxt = SQ_OUT1;
          end
        end else begin
          again_nxt = again_r;
        end
      end
      SQ_OUT1: begin
        again_nxt = again_r;
        if (out_ready) begin
          sq_nxt = rtwo_r ? SQ_OUT2 : (again_r ? SQ_PARSE : SQ_IDLE);
          again_nxt = 1'b0;
          // the note tone, then the end pause or a re-parse of a closing byte that is not a comma
        end
      end
      SQ_OUT2: begin
        if (out_ready) sq_nxt = SQ_IDLE;
      end
      default: sq_nxt = SQ_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vol_r <= VOLUME_RESET;
    end else if (cfg_valid) begin
      vol_r <= cfg_tone_volume;
    end
  end

  logic clr;
  // errors and the end pause clear the parser once their beat leaves
  assign clr = ((sq_r == SQ_OUT1) && out_ready && !rtwo_r && (rst_r != ST_NOTE))
            || ((sq_r == SQ_OUT2) && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      sq_r <= rst_n ? sq_nxt : SQ_IDLE;
      ph_r <= PH_NAME;
      ddur_r <= DUR_RESET; ndur_r <= DUR_RESET;
      doct_r <= OCT_RESET; noct_r <= OCT_RESET;
      tempo_r <= ACC_BITS'(63); acc_r <= '0; let_r <= '0; semi_r <= -6'sd1;
      again_r <= 1'b0; rtwo_r <= 1'b0;
    end else begin
      sq_r <= sq_nxt; ph_r <= ph_nxt;
      ddur_r <= ddur_nxt; ndur_r <= ndur_nxt; doct_r <= doct_nxt; noct_r <= noct_nxt;
      tempo_r <= tempo_nxt; acc_r <= acc_nxt; let_r <= let_nxt; semi_r <= semi_nxt;
      again_r <= again_nxt; rtwo_r <= rtwo_nxt;
    end
    c_r <= c_nxt; dq_r <= dq_nxt; dd_r <= dd_nxt; drem_r <= drem_nxt;
    dcnt_r <= dcnt_nxt; dfrom_ndur_r <= dfrom_ndur_nxt;
    rf_r <= rf_nxt; rms_r <= rms_nxt; rst_r <= rst_nxt; ramp_r <= ramp_nxt;
  end

endmodule
`default_nettype wire

FILE: tb/sv/ringtone_text_to_tone_parser_test.sv
// self-checking test of the ringtone text parser with a scoreboard class
`timescale 1ns / 1ps
`default_nettype none
module ringtone_text_to_tone_parser_test;
  import rtp_pkg::*;

  localparam int ACC_BITS = 16;
  localparam logic [63:0] ACC_MAX = (64'd1 << ACC_BITS) - 64'd1;

  typedef struct packed {
    logic [12:0] freq;
    logic [7:0]  amp;
    logic [19:0] ms;
    logic [1:0]  status;
    logic        is_final;
  } tone_t;

  typedef enum int {
    P_NAME, P_DSTART, P_DEQ, P_DVAL, P_DTAIL, P_NTOP, P_NSKIP, P_NDUR,
    P_SHARP, P_FLAT, P_DOT1, P_OCT, P_DOT2, P_DELIM
  } parse_t;

  class tone_scoreboard;
    tone_t       pending[$];
    int          mismatches;
    logic [7:0]  volume;
    parse_t      phase;
    int unsigned dflt_dur, dflt_oct, note_oct, note_dur, letter;
    logic [63:0] tempo, acc;
    int          semi;
    tone_t       step_out[$];

    function void clear_song();
      phase = P_NAME; dflt_dur = 4; dflt_oct = 6; tempo = 63; acc = 0;
      letter = 0; semi = -1; note_oct = 6; note_dur = 4;
    endfunction

    function void reset_all();
      volume = VOLUME_RESET; mismatches = 0; pending.delete(); clear_song();
    endfunction

    function void push_tone(logic [63:0] f, logic [63:0] a, logic [63:0] ms,
                            logic [1:0] st);
      tone_t t;
      t.freq = f[12:0]; t.amp = a[7:0]; t.ms = ms[19:0]; t.status = st;
      t.is_final = 1'b0;
      step_out.push_back(t);
    endfunction

    function void error_out(logic [1:0] code);
      push_tone(0, 0, 0, code); clear_song();
    endfunction

    function void add_digit(int unsigned c);
      logic [63:0] v;
      v = acc * 10 + (c - "0");
      acc = (v > ACC_MAX) ? ACC_MAX : v;
    endfunction

    function void begin_note();
      phase = P_NTOP; semi = -1; note_oct = dflt_oct; note_dur = dflt_dur; acc = 0;
    endfunction

    function void take_letter(int unsigned c);
      case (c)
        "C", "c": semi = 0;
        "D", "d": semi = 2;
        "E", "e": semi = 4;
        "F", "f": semi = 5;
        "G", "g": semi = 7;
        "A", "a": semi = 9;
        "H", "h", "B", "b": semi = 11;
        default: semi = -1;
      endcase
      phase = P_SHARP;
    endfunction

    function int unsigned top_hz(int i);
      int unsigned tbl[12] = '{4186, 4434, 4698, 4978, 5274, 5587,
                               5919, 6271, 6644, 7040, 7458, 7902};
      return tbl[i];
    endfunction

    function bit play_note();
      logic [63:0] ms, f;
      int k, q, sh;
      if (tempo == 0) begin
        error_out(ST_ZERO);
        return 0;
      end
      ms = (64'(note_dur) * 60000) / (tempo * 8);
      f = 0;
      if (semi != -1) begin
        k = (int'(note_oct) + 1) * 12 + semi;
        q = k / 12;
        sh = (q >= 9) ? 0 : 9 - q;
        f = top_hz(k % 12) >> sh;
      end
      push_tone(f, volume, ms, ST_NOTE);
      return 1;
    endfunction

    function bit is_dig(int unsigned c);
      return c >= "0" && c <= "9";
    endfunction

    // noting an accepted byte: walk the parser and queue what it emits
    function void note_byte(logic [7:0] cb);
      int unsigned c;
      bit again;
      logic [63:0] v;
      c = cb;
      again = 1;
      step_out.delete();
      while (again) begin
        again = 0;
        case (phase)
          P_NAME: begin
            if (c == 0) error_out(ST_FMT);
            else if (c == ":") phase = P_DSTART;
          end
          P_DSTART: begin
            if (c == " ") ;
            else if (c == 0) error_out(ST_FMT);
            else if (c == ":") begin_note();
            else begin
              letter = c; phase = P_DEQ;
            end
          end
          P_DEQ: begin
            if (c == "=") begin
              acc = 0; phase = P_DVAL;
            end else error_out(ST_FMT);
          end
          P_DVAL: begin
            if (is_dig(c)) add_digit(c);
            else begin
              v = acc; acc = 0;
              if (letter == "d" && v == 0) error_out(ST_ZERO);
              else begin
                if (letter == "d") dflt_dur = 32'(64'd32 / v);
                else if (letter == "o") dflt_oct = (v > 15) ? 32'd15 : 32'(v);
                else if (letter == "b") tempo = v;
                phase = P_DTAIL; again = 1;
              end
            end
          end
          P_DTAIL: begin
            if (c != " ") begin
              phase = P_DSTART;
              if (c != ",") again = 1;
            end
          end
          P_NTOP, P_NSKIP: begin
            if (c == " ") phase = P_NSKIP;
            else if (c == 0) begin
              if (phase == P_NTOP) begin
                push_tone(0, 0, END_MS, ST_END); clear_song();
              end else error_out(ST_FMT);
            end else if (is_dig(c)) begin
              acc = 0; add_digit(c); phase = P_NDUR;
            end else take_letter(c);
          end
          P_NDUR: begin
            if (is_dig(c)) add_digit(c);
            else if (acc == 0) error_out(ST_ZERO);
            else begin
              note_dur = 32'(64'd32 / acc); acc = 0;
              if (c == 0) error_out(ST_FMT);
              else take_letter(c);
            end
          end
          P_SHARP: begin
            phase = P_FLAT;
            if (c == "#") semi++; else again = 1;
          end
          P_FLAT: begin
            phase = P_DOT1;
            if (c == "b") semi--; else again = 1;
          end
          P_DOT1: begin
            phase = P_OCT;
            if (c == ".") note_dur += note_dur / 2; else again = 1;
          end
          P_OCT: begin
            phase = P_DOT2;
            if (is_dig(c)) note_oct = c - "0"; else again = 1;
          end
          P_DOT2: begin
            phase = P_DELIM;
            if (c == ".") note_dur += note_dur / 2; else again = 1;
          end
          P_DELIM: begin
            if (c != " ") begin
              if (play_note()) begin
                begin_note();
                if (c != ",") again = 1;
              end
            end
          end
          default: clear_song();
        endcase
      end
      if (step_out.size() > 0) step_out[step_out.size() - 1].is_final = 1'b1;
      foreach (step_out[i]) pending.push_back(step_out[i]);
    endfunction

    function void check_tone(tone_t got);
      tone_t want;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected tone %h", got);
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) begin
          $display("tone mismatch: expected f=%0d a=%0d ms=%0d st=%0d fin=%0d",
                   want.freq, want.amp, want.ms, want.status, want.is_final);
          $display("               got      f=%0d a=%0d ms=%0d st=%0d fin=%0d",
                   got.freq, got.amp, got.ms, got.status, got.is_final);
        end
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_tone_volume = 8'd0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_char_code = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [12:0] out_tone_freq;
  logic [7:0]  out_tone_amplitude;
  logic [19:0] out_tone_ms;
  logic [1:0]  out_status;
  logic        out_is_final;

  tone_scoreboard sb;
  logic [7:0] text_bytes[$];

  ringtone_text_to_tone_parser #(.ACC_BITS(ACC_BITS)) dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_tone_volume(cfg_tone_volume),
    .in_valid(in_valid), .in_ready(in_ready), .in_char_code(in_char_code),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_tone_freq(out_tone_freq), .out_tone_amplitude(out_tone_amplitude),
    .out_tone_ms(out_tone_ms), .out_status(out_status), .out_is_final(out_is_final)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // receiver stall pattern: long open runs mixed with stall stretches
  int stall_left = 0;
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_tone({out_tone_freq, out_tone_amplitude, out_tone_ms, out_status, out_is_final});
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left <= $urandom_range(1, 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(0, 5) != 0);
    end
  end

  task automatic send_bytes();
    int burst;
    int gap;
    logic [7:0] b;
    burst = 0;
    while (text_bytes.size() > 0) begin
      if (burst == 0) begin
        gap = $urandom_range(0, 30);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst = $urandom_range(1, 20);
      end
      b = text_bytes.pop_front();
      in_valid <= 1'b1;
      in_char_code <= b;
      @(posedge clk);
      while (!in_ready) @(posedge clk);
      sb.note_byte(b);
      burst--;
    end
    in_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic write_volume(logic [7:0] v);
    cfg_valid <= 1'b1;
    cfg_tone_volume <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    sb.volume = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) text_bytes.push_back(s.getc(i));
  endtask

  function automatic string pick(string opts[$]);
    return opts[$urandom_range(0, opts.size() - 1)];
  endfunction

  // a well-formed song with random content, sometimes broken on purpose
  task automatic add_song();
    int notes;
    if ($urandom_range(0, 1)) add_text("tune");
    add_text(":");
    if ($urandom_range(0, 3) != 0) add_text($sformatf("d=%0d,", $urandom_range(1, 32)));
    if ($urandom_range(0, 3) != 0) add_text($sformatf("o=%0d,", $urandom_range(0, 20)));
    if ($urandom_range(0, 3) != 0)
      add_text($sformatf("b=%0d", $urandom_range(0, 9) == 0 ? 0 : $urandom_range(1, 300)));
    if ($urandom_range(0, 7) == 0) add_text(" x=7 ");
    add_text(":");
    notes = $urandom_range(1, 6);
    for (int i = 0; i < notes; i++) begin
      if ($urandom_range(0, 2) == 0) add_text(pick('{"1", "2", "4", "8", "16", "32", "0", "99"}));
      add_text(pick('{"c", "d", "e", "f", "g", "a", "b", "h", "p", "C", "H", "x"}));
      if ($urandom_range(0, 3) == 0) add_text("#");
      if ($urandom_range(0, 5) == 0) add_text("b");
      if ($urandom_range(0, 3) == 0) add_text(".");
      if ($urandom_range(0, 2) == 0) add_text($sformatf("%0d", $urandom_range(0, 9)));
      if ($urandom_range(0, 5) == 0) add_text(".");
      if (i != notes - 1) add_text($urandom_range(0, 4) == 0 ? ", " : ",");
    end
    if ($urandom_range(0, 9) == 0) text_bytes.push_back(8'($urandom_range(0, 255)));
    text_bytes.push_back(8'd0);
  endtask

  initial begin
    sb = new();
    sb.reset_all();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: defaults, sharps, flats, dots, errors, end after letter
    add_text(":d=4,o=5,b=100:8c#.6.,p#,cb,h7 ,32a.,");
    text_bytes.push_back(8'd0);
    add_text(":d=0:"); add_text("n:b=0:c,"); add_text("q");
    text_bytes.push_back(8'd0);
    send_bytes();
    wait_drained();
    write_volume(8'd255);
    add_text(":o=99,b=65535:99999c,0");
    text_bytes.push_back(8'hFF);
    add_text(":: ");
    text_bytes.push_back(8'd0);
    add_text("::4");
    text_bytes.push_back(8'd0);
    add_text("::e");
    text_bytes.push_back(8'd0);
    send_bytes();
    wait_drained();

    for (int phase_no = 0; phase_no < 4; phase_no++) begin
      write_volume(phase_no == 0 ? 8'd0 : 8'($urandom_range(0, 255)));
      while (text_bytes.size() < 150) begin
        if ($urandom_range(0, 9) == 0)
          repeat ($urandom_range(1, 4)) text_bytes.push_back(8'($urandom_range(0, 255)));
        else add_song();
      end
      send_bytes();
      wait_drained();
    end

    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS ringtone_text_to_tone_parser");
    end else begin
      $display("FAIL ringtone_text_to_tone_parser");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL ringtone_text_to_tone_parser");
    $finish;
  end
endmodule
`default_nettype wire
